// ----- hdl/vcs_pkg.sv -----
// Shared types and constants of the velocity command shaper.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package vcs_pkg;

  // Defaults of the top-level parameters
  localparam int unsigned VCS_DEFAULT_TICK = 500;
  localparam int unsigned VCS_VEL_WIDTH    = 16;

  // Quotient bits of the alpha and ratio division
  localparam int unsigned DIV_BITS = 16;

  // Item command codes
  localparam logic CMD_SET_TARGET = 1'b0;
  localparam logic CMD_TICK       = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_EN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_EN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TAU_LIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TAU_ANG     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_T_LIN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_T_ANG  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LIN     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ANG     = 3'd7;
  localparam int unsigned CFG_DATA_W = 16;

  // Register reset values
  localparam logic [15:0] TAU_LIN_RST    = 16'd3000;
  localparam logic [15:0] TAU_ANG_RST    = 16'd2000;
  localparam logic [15:0] RAMP_T_LIN_RST = 16'd6000;
  localparam logic [15:0] RAMP_T_ANG_RST = 16'd6000;
  localparam logic [14:0] MAX_LIN_RST    = 15'd6554;
  localparam logic [14:0] MAX_ANG_RST    = 15'd13107;

  // Shortest ramp time, 10 ms in 100 us units
  localparam logic [15:0] RAMP_T_MIN = 16'd100;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_MUL_F,
    S_UPD_F,
    S_MUL_R,
    S_UPD_R,
    S_WRITE
  } vcs_state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic store_target;
    logic tick_start;
    logic div_step;
    logic mul_filter;
    logic upd_filter;
    logic mul_ramp;
    logic upd_ramp;
    logic load_out;
  } vcs_cmd_t;

endpackage

// ----- hdl/vcs_div.sv -----
// Restoring divider, one quotient bit per step: floor(dividend * 2^16 / divisor).
// Depends on vcs_pkg. The dividend must be below the divisor for a valid result.
`timescale 1ns / 1ps

module vcs_div import vcs_pkg::*; (
  input  logic                clk_i,
  input  logic                start_i,
  input  logic                step_i,
  input  logic [15:0]         dividend_i,
  input  logic [16:0]         divisor_i,
  output logic [DIV_BITS-1:0] quot_o
);

  logic [17:0]         rem_q, rem_d;
  logic [DIV_BITS-1:0] quot_q, quot_d;
  logic [17:0]         shifted;
  logic                ge;

  assign shifted = {rem_q[16:0], 1'b0};
  assign ge      = shifted >= {1'b0, divisor_i};

  always_comb begin
    rem_d  = rem_q;
    quot_d = quot_q;
    if (start_i) begin
      rem_d  = {2'b00, dividend_i};
      quot_d = '0;
    end else if (step_i) begin
      rem_d  = ge ? (shifted - {1'b0, divisor_i}) : shifted;
      quot_d = {quot_q[DIV_BITS-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
  end

  assign quot_o = quot_q;

endmodule

// ----- hdl/vcs_dp.sv -----
// Datapath of the velocity command shaper: config registers, target clamp,
// four alpha/ratio dividers, three filter/ramp lanes and the result register.
// Depends on vcs_pkg and vcs_div.
`timescale 1ns / 1ps

module vcs_dp import vcs_pkg::*; #(
  parameter int unsigned DEFAULT_TICK = VCS_DEFAULT_TICK,
  parameter int unsigned VEL_WIDTH    = VCS_VEL_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  vcs_cmd_t              cmd_i,
  output logic                  div_done_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic signed [15:0]    target_vx_i,
  input  logic signed [15:0]    target_vy_i,
  input  logic signed [15:0]    target_vth_i,
  input  logic [15:0]           elapsed_time_i,
  output logic signed [15:0]    out_vx_o,
  output logic signed [15:0]    out_vy_o,
  output logic signed [15:0]    out_vth_o
);

  localparam int unsigned XW  = (VEL_WIDTH > 14) ? VEL_WIDTH + 3 : 17;
  localparam int unsigned DFW = VEL_WIDTH + 1;
  localparam int unsigned PW  = VEL_WIDTH + 19;
  localparam int unsigned CW  = $clog2(DIV_BITS);
  localparam logic signed [XW-1:0] VMAX_X =
    XW'((64'sd1 <<< (VEL_WIDTH - 1)) - 64'sd1);
  localparam logic signed [XW-1:0] VMIN_X = -VMAX_X - XW'(1);
  localparam logic [16:0] WEIGHT_ONE = 17'h10000;

  // Configuration registers
  logic        smooth_en_q, ramp_en_q;
  logic [15:0] tau_lin_q, tau_ang_q, ramp_t_lin_q, ramp_t_ang_q;
  logic [14:0] max_lin_q, max_ang_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smooth_en_q  <= 1'b1;
      ramp_en_q    <= 1'b1;
      tau_lin_q    <= TAU_LIN_RST;
      tau_ang_q    <= TAU_ANG_RST;
      ramp_t_lin_q <= RAMP_T_LIN_RST;
      ramp_t_ang_q <= RAMP_T_ANG_RST;
      max_lin_q    <= MAX_LIN_RST;
      max_ang_q    <= MAX_ANG_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SMOOTH_EN:  smooth_en_q  <= cfg_wdata_i[0];
        CFG_RAMP_EN:    ramp_en_q    <= cfg_wdata_i[0];
        CFG_TAU_LIN:    tau_lin_q    <= cfg_wdata_i;
        CFG_TAU_ANG:    tau_ang_q    <= cfg_wdata_i;
        CFG_RAMP_T_LIN: ramp_t_lin_q <= cfg_wdata_i;
        CFG_RAMP_T_ANG: ramp_t_ang_q <= cfg_wdata_i;
        CFG_MAX_LIN:    max_lin_q    <= cfg_wdata_i[14:0];
        CFG_MAX_ANG:    max_ang_q    <= cfg_wdata_i[14:0];
        default: ;
      endcase
    end
  end

  // Tick interval and divisors
  logic [15:0] dt_in, dt_q;
  logic [15:0] tau_lin_eff, tau_ang_eff, rt_lin_eff, rt_ang_eff;
  logic        ge_lin_q, ge_ang_q;
  logic [CW-1:0] div_cnt_q;

  assign dt_in       = (elapsed_time_i == '0) ? 16'(DEFAULT_TICK) : elapsed_time_i;
  assign tau_lin_eff = (tau_lin_q == '0) ? 16'd1 : tau_lin_q;
  assign tau_ang_eff = (tau_ang_q == '0) ? 16'd1 : tau_ang_q;
  assign rt_lin_eff  = (ramp_t_lin_q < RAMP_T_MIN) ? RAMP_T_MIN : ramp_t_lin_q;
  assign rt_ang_eff  = (ramp_t_ang_q < RAMP_T_MIN) ? RAMP_T_MIN : ramp_t_ang_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.tick_start) begin
      dt_q     <= dt_in;
      ge_lin_q <= dt_in >= rt_lin_eff;
      ge_ang_q <= dt_in >= rt_ang_eff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (cmd_i.tick_start) begin
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      div_cnt_q <= div_cnt_q + CW'(1);
    end
  end

  assign div_done_o = cmd_i.div_step && (div_cnt_q == CW'(DIV_BITS - 1));

  logic [DIV_BITS-1:0] flt_gain_lin, flt_gain_ang, rmp_gain_lin, rmp_gain_ang;

  vcs_div u_div_flt_lin (
    .clk_i      (clk_i),
    .start_i    (cmd_i.tick_start),
    .step_i     (cmd_i.div_step),
    .dividend_i (dt_in),
    .divisor_i  ({1'b0, tau_lin_eff} + {1'b0, dt_q}),
    .quot_o     (flt_gain_lin)
  );

  vcs_div u_div_flt_ang (
    .clk_i      (clk_i),
    .start_i    (cmd_i.tick_start),
    .step_i     (cmd_i.div_step),
    .dividend_i (dt_in),
    .divisor_i  ({1'b0, tau_ang_eff} + {1'b0, dt_q}),
    .quot_o     (flt_gain_ang)
  );

  vcs_div u_div_rmp_lin (
    .clk_i      (clk_i),
    .start_i    (cmd_i.tick_start),
    .step_i     (cmd_i.div_step),
    .dividend_i (dt_in),
    .divisor_i  ({1'b0, rt_lin_eff}),
    .quot_o     (rmp_gain_lin)
  );

  vcs_div u_div_rmp_ang (
    .clk_i      (clk_i),
    .start_i    (cmd_i.tick_start),
    .step_i     (cmd_i.div_step),
    .dividend_i (dt_in),
    .divisor_i  ({1'b0, rt_ang_eff}),
    .quot_o     (rmp_gain_ang)
  );

  // Lanes: x and y use the linear settings, yaw rate the angular ones
  logic signed [15:0]          tin [3];
  logic signed [VEL_WIDTH-1:0] tgt_q [3];
  logic signed [VEL_WIDTH-1:0] filt_q [3];
  logic signed [VEL_WIDTH-1:0] cur_q [3];
  logic signed [PW-1:0]        prod_q [3];

  assign tin[0] = target_vx_i;
  assign tin[1] = target_vy_i;
  assign tin[2] = target_vth_i;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    localparam bit ANG = (i == 2);

    logic [14:0]                 mag;
    logic [16:0]                 w_filt, w_ramp;
    logic signed [XW-1:0]        clamp_v, clamp_m;
    logic signed [VEL_WIDTH-1:0] clamp_res;
    logic signed [DFW-1:0]       diff;
    logic signed [PW-1:0]        prod_d, prod_sh;
    logic signed [XW-1:0]        sum, sum_sat;
    logic signed [VEL_WIDTH-1:0] base;

    assign mag    = ANG ? max_ang_q : max_lin_q;
    assign w_filt = {1'b0, ANG ? flt_gain_ang : flt_gain_lin};
    assign w_ramp = (ANG ? ge_ang_q : ge_lin_q) ? WEIGHT_ONE
                                                : {1'b0, ANG ? rmp_gain_ang : rmp_gain_lin};

    // Clamp to the magnitude limit, then to the state range
    always_comb begin
      clamp_m = XW'({1'b0, mag});
      clamp_v = XW'(tin[i]);
      if (clamp_v > clamp_m) clamp_v = clamp_m;
      if (clamp_v < -clamp_m) clamp_v = -clamp_m;
      if (clamp_v > VMAX_X) clamp_v = VMAX_X;
      if (clamp_v < VMIN_X) clamp_v = VMIN_X;
      clamp_res = VEL_WIDTH'(clamp_v);
    end

    // One multiplier per lane, shared by the filter and the ramp step
    always_comb begin
      if (cmd_i.mul_ramp) begin
        diff   = DFW'(filt_q[i]) - DFW'(cur_q[i]);
        prod_d = PW'($signed({1'b0, w_ramp})) * PW'(diff);
      end else begin
        diff   = DFW'(tgt_q[i]) - DFW'(filt_q[i]);
        prod_d = PW'($signed({1'b0, w_filt})) * PW'(diff);
      end
    end

    // Floor by arithmetic shift, add, saturate
    always_comb begin
      base    = cmd_i.upd_ramp ? cur_q[i] : filt_q[i];
      prod_sh = prod_q[i] >>> 16;
      sum     = XW'(base) + XW'(prod_sh);
      sum_sat = sum;
      if (sum > VMAX_X) sum_sat = VMAX_X;
      if (sum < VMIN_X) sum_sat = VMIN_X;
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.mul_filter || cmd_i.mul_ramp) begin
        prod_q[i] <= prod_d;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tgt_q[i]  <= '0;
        filt_q[i] <= '0;
        cur_q[i]  <= '0;
      end else begin
        if (cmd_i.store_target) begin
          tgt_q[i] <= clamp_res;
        end
        if (cmd_i.upd_filter) begin
          filt_q[i] <= smooth_en_q ? VEL_WIDTH'(sum_sat) : tgt_q[i];
        end
        if (cmd_i.upd_ramp) begin
          cur_q[i] <= ramp_en_q ? VEL_WIDTH'(sum_sat) : filt_q[i];
        end
      end
    end
  end

  // Result register
  logic signed [15:0] out_vx_q, out_vy_q, out_vth_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_vx_q  <= 16'(cur_q[0]);
      out_vy_q  <= 16'(cur_q[1]);
      out_vth_q <= 16'(cur_q[2]);
    end
  end

  assign out_vx_o  = out_vx_q;
  assign out_vy_o  = out_vy_q;
  assign out_vth_o = out_vth_q;

endmodule

// ----- hdl/vcs_ctrl.sv -----
// Controller of the velocity command shaper: item handshake, tick sequence
// and result valid flag. Depends on vcs_pkg.
`timescale 1ns / 1ps

module vcs_ctrl import vcs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     cmd_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  logic     div_done_i,
  output vcs_cmd_t cmd_o
);

  vcs_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (cmd_i == CMD_TICK) begin
            cmd_o.tick_start = 1'b1;
            state_d          = S_DIV;
          end else begin
            cmd_o.store_target = 1'b1;
          end
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (div_done_i) state_d = S_MUL_F;
      end
      S_MUL_F: begin
        cmd_o.mul_filter = 1'b1;
        state_d          = S_UPD_F;
      end
      S_UPD_F: begin
        cmd_o.upd_filter = 1'b1;
        state_d          = S_MUL_R;
      end
      S_MUL_R: begin
        cmd_o.mul_ramp = 1'b1;
        state_d        = S_UPD_R;
      end
      S_UPD_R: begin
        cmd_o.upd_ramp = 1'b1;
        state_d        = S_WRITE;
      end
      S_WRITE: begin
        // hold until the result register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = cmd_o.load_out | (out_valid_q & ~out_ready_i);
  assign out_valid_o = out_valid_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten while still full");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done_i |-> (state_q == S_DIV))
    else $error("divider done outside the divide phase");

  a_tick_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && cmd_i == CMD_TICK) |=> (state_q == S_DIV))
    else $error("accepted tick did not start the divide phase");

  a_target_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && cmd_i == CMD_SET_TARGET) |=> (state_q == S_IDLE))
    else $error("set_target left the idle state");

  a_ramp_then_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD_R) |=> (state_q == S_WRITE))
    else $error("ramp update not followed by result write");

endmodule

// ----- hdl/velocity_command_shaper.sv -----
// Velocity command shaper top level: controller and datapath.
// Depends on vcs_pkg, vcs_ctrl, vcs_dp (and vcs_div below it).
//
//   channel   handshake                 payload
//   in        in_valid_i / in_ready_o   cmd_i, target_v{x,y,th}_i, elapsed_time_i
//   out       out_valid_o / out_ready_i out_vx_o, out_vy_o, out_vth_o
//   cfg       cfg_we_i (no wait)        cfg_idx_i, cfg_wdata_i
//
// A set_target item is stored at once; the next item is taken in the following cycle.
// A tick item runs through accept, 16 divider steps (one quotient bit per cycle
// in four parallel dividers), two multiply/update pairs, and the result write.
// The result register frees the input side: items are taken while a result waits,
// but a following tick holds in its write step until that result is taken.
// Reset clears the targets, filter and velocity state and loads register defaults.
`timescale 1ns / 1ps

module velocity_command_shaper import vcs_pkg::*; #(
  parameter int unsigned DEFAULT_TICK = VCS_DEFAULT_TICK,
  parameter int unsigned VEL_WIDTH    = VCS_VEL_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  cmd_i,
  input  logic signed [15:0]    target_vx_i,
  input  logic signed [15:0]    target_vy_i,
  input  logic signed [15:0]    target_vth_i,
  input  logic [15:0]           elapsed_time_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic signed [15:0]    out_vx_o,
  output logic signed [15:0]    out_vy_o,
  output logic signed [15:0]    out_vth_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  vcs_cmd_t cmd;
  logic     div_done;

  vcs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .div_done_i  (div_done),
    .cmd_o       (cmd)
  );

  vcs_dp #(
    .DEFAULT_TICK (DEFAULT_TICK),
    .VEL_WIDTH    (VEL_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .div_done_o     (div_done),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .target_vx_i    (target_vx_i),
    .target_vy_i    (target_vy_i),
    .target_vth_i   (target_vth_i),
    .elapsed_time_i (elapsed_time_i),
    .out_vx_o       (out_vx_o),
    .out_vy_o       (out_vy_o),
    .out_vth_o      (out_vth_o)
  );

endmodule
